FILE: design/rric_pkg.sv
`timescale 1ns / 1ps
package rric_pkg;
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_TACHY = 3'd1,
    CLS_BRADY = 3'd2,
    CLS_AF    = 3'd3,
    CLS_IRREG = 3'd4
  } cls_e;

  typedef enum logic [1:0] {
    REG_TACHY = 2'd0,
    REG_BRADY = 2'd1,
    REG_CV    = 2'd2
  } reg_e;

  localparam int unsigned RateW = 13;
  localparam int unsigned CvW   = 10;
  localparam int unsigned RrW   = 16;
  localparam logic [19:0] RrNum = 20'd960000;
  localparam logic [15:0] MinBeats = 16'd5;

  // queue entry between front and back
  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [RrW-1:0]   beats;
  } beat_t;
endpackage

FILE: design/rric_front.sv
`timescale 1ns / 1ps
module rric_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [12:0]         rate_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output rric_pkg::beat_t     q_data_o
);
  import rric_pkg::*;

  logic [15:0] beats_q, beats_d;
  beat_t       fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign in_stall  = (cnt_q == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rp_q];
  assign beats_d   = (beats_q == 16'hFFFF) ? beats_q : beats_q + 16'd1;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{rate: rate_i, beats: beats_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beats_q <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (push) begin
        beats_q <= beats_d;
        wp_q    <= ~wp_q;
      end
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_beats_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> beats_q != 16'd0) else $error("beat counter wrapped");
`endif
endmodule

FILE: design/rric_back.sv
`timescale 1ns / 1ps
module rric_back #(
  parameter int unsigned RingDepth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  rric_pkg::beat_t     q_data_i,
  input  logic [12:0]         tachy_i,
  input  logic [12:0]         brady_i,
  input  logic [9:0]          cv_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          cls_o,
  output logic [15:0]         rr_o,
  output logic                stored_o,
  output logic [15:0]         beats_o
);
  import rric_pkg::*;

  localparam int unsigned PtrW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned NW   = $clog2(RingDepth + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_WALK, ST_MULA, ST_MULB, ST_CMP, ST_OUT
  } st_e;

  st_e st_q, st_d;
  logic [15:0] ring_q [RingDepth];
  logic [PtrW-1:0] ptr_q, wi_q;
  logic [4:0]  cnt_q;
  logic [19:0] rem_q;
  logic [19:0] quo_q;
  logic [12:0] rate_q;
  logic [15:0] beats_q;
  logic [15:0] rr_q, rr_d;
  logic        stored_q;
  logic [NW-1:0] n_q;
  logic [20:0] s_q;
  logic [36:0] qs_q;
  logic [2:0]  cls_q;
  logic [63:0] dev_q, s2_q;
  logic [19:0] t2_q;
  logic [83:0] lhs_q, rhs_q;
  logic [15:0] v;
  logic [20:0] trial;
  logic [63:0] nq;

  assign v     = ring_q[wi_q];
  assign trial = {rem_q, quo_q[19]} - {8'd0, rate_q};
  assign nq    = 64'(n_q) * 64'(qs_q);
  assign rr_d  = (rate_q == '0) ? 16'd0 : (quo_q[19:16] != '0) ? 16'hFFFF : quo_q[15:0];

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      ST_IDLE: if (q_valid_i) st_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'd0) st_d = ST_WALK;
      ST_WALK: if (wi_q == PtrW'(RingDepth - 1)) st_d = ST_MULA;
      ST_MULA: st_d = ST_MULB;
      ST_MULB: st_d = ST_CMP;
      ST_CMP:  st_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          st_d    = ST_IDLE;
          q_pop_o = 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      ptr_q <= '0;
      for (int i = 0; i < RingDepth; i++) ring_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_DIV && cnt_q == 5'd0 && rate_q != '0) begin
        ring_q[ptr_q] <= rr_d;
        ptr_q <= (ptr_q == PtrW'(RingDepth - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        rate_q   <= q_data_i.rate;
        beats_q  <= q_data_i.beats;
        rem_q    <= '0;
        quo_q    <= RrNum;
        cnt_q    <= 5'd20;
        stored_q <= (q_data_i.rate != '0);
      end
      ST_DIV: begin
        if (cnt_q != 5'd0) begin
          if (!trial[20]) begin
            rem_q <= trial[19:0];
            quo_q <= {quo_q[18:0], 1'b1};
          end else begin
            rem_q <= {rem_q[18:0], quo_q[19]};
            quo_q <= {quo_q[18:0], 1'b0};
          end
          cnt_q <= cnt_q - 5'd1;
        end else begin
          rr_q <= rr_d;
          wi_q <= '0;
          n_q  <= '0;
          s_q  <= '0;
          qs_q <= '0;
        end
      end
      ST_WALK: begin
        if (v != 16'd0) begin
          n_q  <= n_q + 1'b1;
          s_q  <= s_q + 21'(v);
          qs_q <= qs_q + 37'(32'(v) * 32'(v));
        end
        wi_q <= wi_q + 1'b1;
      end
      ST_MULA: begin
        dev_q <= nq;
        s2_q  <= 64'(42'(s_q) * 42'(s_q));
        t2_q  <= 20'(cv_i) * 20'(cv_i);
      end
      ST_MULB: begin
        lhs_q <= 84'(dev_q - s2_q) * 84'd1000000;
        rhs_q <= 84'(s2_q) * 84'(t2_q);
      end
      ST_CMP: begin
        cls_q <= CLS_NONE;
        if (beats_q >= MinBeats) begin
          if (rate_q > tachy_i) cls_q <= CLS_TACHY;
          else if (rate_q < brady_i && rate_q != '0) cls_q <= CLS_BRADY;
          else if (n_q >= NW'(3)) begin
            if (lhs_q > {rhs_q[81:0], 2'b00}) cls_q <= CLS_AF;
            else if (lhs_q > rhs_q) cls_q <= CLS_IRREG;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid = (st_q == ST_OUT);
  assign cls_o     = cls_q;
  assign rr_o      = rr_q;
  assign stored_o  = stored_q;
  assign beats_o   = beats_q;

`ifndef NO_ASSERTIONS
  a_pop_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> out_valid && !out_stall) else $error("pop without delivery");
  a_stored_rr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (stored_o == (rr_o != 16'd0))) else $error("stored flag mismatch");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
`endif
endmodule

FILE: design/rr_interval_rhythm_classifier.sv
`timescale 1ns / 1ps
// Beat rhythm classifier. Each transaction on the input carries one beat's rate
// (1/16 bpm) and yields one result: class, stored RR interval in ms, stored flag
// and saturating beat count. A two-entry queue decouples intake from the compute
// engine, which works on one beat at a time: it loads the beat, runs the
// bit-serial 960000/rate divider, walks the ring entries for the sum, forms the
// spread products and compares, then holds the result in the output state while
// the output is stalled and pops the beat from the queue once it is taken.
module rr_interval_rhythm_classifier #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [12:0] beat_rate_x16_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  rhythm_class_o,
  output logic [15:0] rr_ms_o,
  output logic        rr_stored_o,
  output logic [15:0] beat_count_o
);
  import rric_pkg::*;

  logic [12:0] tachy_q, brady_q;
  logic [9:0]  cv_q;
  logic        q_valid, q_pop;
  beat_t       q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tachy_q <= 13'd1920;
      brady_q <= 13'd800;
      cv_q    <= 10'd150;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TACHY: tachy_q <= cfg_data_i;
        REG_BRADY: brady_q <= cfg_data_i;
        REG_CV:    cv_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  rric_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .rate_i(beat_rate_x16_i), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  rric_back #(.RingDepth(RING_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .tachy_i(tachy_q), .brady_i(brady_q), .cv_i(cv_q),
    .out_valid, .out_stall, .cls_o(rhythm_class_o), .rr_o(rr_ms_o),
    .stored_o(rr_stored_o), .beats_o(beat_count_o)
  );
endmodule
